// ===== rtl/ppcbg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcbg_pkg
// Shared types, constants and parity functions of the packet check byte
// generator.
// ----------------------------------------------------------------------------
package ppcbg_pkg;

  localparam int COMMAND_LIMIT = 128;
  localparam int CHECK_DEPTH   = 43;
  localparam int CHECK_AW      = $clog2(CHECK_DEPTH);
  localparam int DROP_LIMIT    = 255;
  localparam int QDEPTH        = 2;
  localparam int QAW           = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW           = $clog2(QDEPTH + 1);

  localparam logic [1:0] POS_LAST = 2'd2;

  localparam logic [7:0] PARITY_MASK [5][4] = '{
    '{8'hc0, 8'hc3, 8'hff, 8'h09},
    '{8'h38, 8'h3a, 8'h7e, 8'h13},
    '{8'h26, 8'hb5, 8'hb9, 8'h23},
    '{8'h95, 8'h6c, 8'hd5, 8'h43},
    '{8'h4b, 8'hdc, 8'he2, 8'h83}
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] packet_size;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_check;
    logic       frame_end;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic                reject;
    logic [7:0]          data;
    logic [1:0]          pos_mod;
    logic [CHECK_AW-1:0] group;
    logic                last;
  } cmd_t;

  function automatic logic [4:0] absorb(input logic [4:0] gp, input logic [7:0] v,
                                        input logic [1:0] pos);
    logic [4:0] r;
    r = gp;
    for (int b = 0; b < 5; b++) begin
      r[b] = r[b] ^ (^(v & PARITY_MASK[b][pos]));
    end
    return r;
  endfunction

  function automatic logic [7:0] finish(input logic [4:0] gp,
                                        input logic [CHECK_AW-1:0] t);
    logic [7:0] sum;
    sum = {5'd0, t[2:0]};
    for (int b = 0; b < 5; b++) begin
      if (gp[b] ^ (^(sum & PARITY_MASK[b][3]))) begin
        sum[b+3] = ~sum[b+3];
      end
    end
    return sum;
  endfunction

endpackage

// ===== rtl/ppcbg_ram.sv =====
// ----------------------------------------------------------------------------
// ppcbg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppcbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 43
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ppcbg_front.sv =====
// ----------------------------------------------------------------------------
// ppcbg_front
// Intake: tracks byte position and sequence number, drops oversize packets
// and turns each kept byte into a command for the back end.
// ----------------------------------------------------------------------------
module ppcbg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ppcbg_pkg::in_item_t in_item,
  output logic               q_push,
  output ppcbg_pkg::cmd_t    q_cmd,
  input  logic               q_full
);
  import ppcbg_pkg::*;

  logic [7:0]          byte_count, byte_count_next;
  logic [1:0]          pos_mod, pos_mod_next;
  logic [CHECK_AW-1:0] group, group_next;
  logic [1:0]          seq, seq_next;
  logic                dropping, dropping_next;

  logic       accept;
  logic [8:0] n;
  logic       too_large;
  logic       last;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign n         = {1'b0, byte_count} + 9'd1;
  assign too_large = (in_item.packet_size >= 8'(COMMAND_LIMIT)) ||
                     (in_item.packet_size == 8'd0);
  assign last      = (n >= {1'b0, in_item.packet_size}) || (n >= 9'(COMMAND_LIMIT - 1));

  always_comb begin
    byte_count_next = byte_count;
    pos_mod_next    = pos_mod;
    group_next      = group;
    seq_next        = seq;
    dropping_next   = dropping;
    q_push          = 1'b0;
    q_cmd.reject    = 1'b0;
    q_cmd.data      = in_item.data_byte;
    q_cmd.pos_mod   = pos_mod;
    q_cmd.group     = group;
    q_cmd.last      = last;
    if (byte_count == 8'd0) begin
      q_cmd.data = {1'b0, seq, in_item.data_byte[4:0]};
    end
    if (accept) begin
      if (dropping) begin
        if ((n >= {1'b0, in_item.packet_size}) || (n >= 9'(DROP_LIMIT))) begin
          dropping_next   = 1'b0;
          byte_count_next = 8'd0;
        end else begin
          byte_count_next = n[7:0];
        end
      end else if (byte_count == 8'd0 && too_large) begin
        q_push       = 1'b1;
        q_cmd.reject = 1'b1;
        if (in_item.packet_size > 8'd1) begin
          dropping_next   = 1'b1;
          byte_count_next = 8'd1;
        end
      end else begin
        q_push = 1'b1;
        if (last) begin
          byte_count_next = 8'd0;
          pos_mod_next    = 2'd0;
          group_next      = '0;
          seq_next        = seq + 2'd1;
        end else begin
          byte_count_next = n[7:0];
          if (pos_mod == POS_LAST) begin
            pos_mod_next = 2'd0;
            group_next   = group + CHECK_AW'(1);
          end else begin
            pos_mod_next = pos_mod + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 8'd0;
      pos_mod    <= 2'd0;
      group      <= '0;
      seq        <= 2'd0;
      dropping   <= 1'b0;
    end else begin
      byte_count <= byte_count_next;
      pos_mod    <= pos_mod_next;
      group      <= group_next;
      seq        <= seq_next;
      dropping   <= dropping_next;
    end
  end

endmodule

// ===== rtl/ppcbg_queue.sv =====
// ----------------------------------------------------------------------------
// ppcbg_queue
// Short command queue between intake and check byte engine.
// ----------------------------------------------------------------------------
module ppcbg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ppcbg_pkg::cmd_t wr_cmd,
  output logic            full,
  output logic            empty,
  output ppcbg_pkg::cmd_t rd_cmd,
  input  logic            rd
);
  import ppcbg_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           do_wr, do_rd;

  assign full   = (count == QCW'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = entries[rd_ptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

// ===== rtl/ppcbg_back.sv =====
// ----------------------------------------------------------------------------
// ppcbg_back
// Check byte engine: parity accumulation, check store, short group fill and
// check byte readout into the result register.
// ----------------------------------------------------------------------------
module ppcbg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  ppcbg_pkg::cmd_t      q_cmd,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output ppcbg_pkg::out_item_t out_item
);
  import ppcbg_pkg::*;

  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_FILL      = 3'd1;
  localparam logic [2:0] ST_FILL_ABS  = 3'd2;
  localparam logic [2:0] ST_FILL_WR   = 3'd3;
  localparam logic [2:0] ST_DRAIN_RD  = 3'd4;
  localparam logic [2:0] ST_DRAIN_OUT = 3'd5;

  logic [2:0]          state, state_next;
  logic [4:0]          gp, gp_next;
  logic [CHECK_AW-1:0] t, t_next;
  logic [CHECK_AW-1:0] k, k_next;
  logic [1:0]          fill_q, fill_q_next;
  logic                out_valid, out_valid_next;
  out_item_t           out_data, out_data_next;

  logic                out_free;
  logic [4:0]          gp_abs;
  logic [CHECK_AW-1:0] fill_idx;
  logic                ram_we, ram_re;
  logic [CHECK_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  ppcbg_ram #(
    .WIDTH(8),
    .DEPTH(CHECK_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign out_item = out_data;
  // k counts the borrowed check bytes of the short group and then indexes the check byte readout
  assign fill_idx = k;

  always_comb begin
    state_next     = state;
    gp_next        = gp;
    t_next         = t;
    k_next         = k;
    fill_q_next    = fill_q;
    out_valid_next = out_valid && !pop;
    out_data_next  = out_data;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = t;
    ram_wdata      = finish(gp, t);
    ram_re         = 1'b0;
    ram_raddr      = k;
    gp_abs         = absorb(gp, q_cmd.data, q_cmd.pos_mod);
    case (state)
      ST_RUN: begin
        if (!q_empty && out_free) begin
          q_pop          = 1'b1;
          out_valid_next = 1'b1;
          if (q_cmd.reject) begin
            out_data_next.out_byte  = 8'd0;
            out_data_next.is_check  = 1'b0;
            out_data_next.frame_end = 1'b0;
            out_data_next.rejected  = 1'b1;
          end else begin
            out_data_next.out_byte  = q_cmd.data;
            out_data_next.is_check  = 1'b0;
            out_data_next.frame_end = 1'b0;
            out_data_next.rejected  = 1'b0;
            if (q_cmd.pos_mod == POS_LAST) begin
              ram_we    = 1'b1;
              ram_waddr = q_cmd.group;
              ram_wdata = finish(gp_abs, q_cmd.group);
              gp_next   = 5'd0;
            end else begin
              gp_next = gp_abs;
            end
            if (q_cmd.last) begin
              t_next = q_cmd.group;
              k_next = '0;
              if (q_cmd.pos_mod == POS_LAST) begin
                state_next = ST_DRAIN_RD;
              end else begin
                fill_q_next = q_cmd.pos_mod + 2'd1;
                state_next  = ST_FILL;
              end
            end
          end
        end
      end
      ST_FILL: begin
        if (fill_idx < t) begin
          ram_re     = 1'b1;
          ram_raddr  = fill_idx;
          state_next = ST_FILL_ABS;
        end else if (fill_q == POS_LAST) begin
          state_next = ST_FILL_WR;
        end else begin
          fill_q_next = POS_LAST;
          k_next      = k + CHECK_AW'(1);
        end
      end
      ST_FILL_ABS: begin
        gp_next = absorb(gp, ram_rdata, fill_q);
        if (fill_q == POS_LAST) begin
          state_next = ST_FILL_WR;
        end else begin
          fill_q_next = POS_LAST;
          k_next      = k + CHECK_AW'(1);
          state_next  = ST_FILL;
        end
      end
      ST_FILL_WR: begin
        ram_we     = 1'b1;
        gp_next    = 5'd0;
        k_next     = '0;
        state_next = ST_DRAIN_RD;
      end
      ST_DRAIN_RD: begin
        ram_re     = 1'b1;
        state_next = ST_DRAIN_OUT;
      end
      ST_DRAIN_OUT: begin
        if (out_free) begin
          out_valid_next          = 1'b1;
          out_data_next.out_byte  = ram_rdata;
          out_data_next.is_check  = 1'b1;
          out_data_next.frame_end = (k == t);
          out_data_next.rejected  = 1'b0;
          if (k == t) begin
            state_next = ST_RUN;
          end else begin
            k_next     = k + CHECK_AW'(1);
            state_next = ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      gp        <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gp        <= gp_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    t        <= t_next;
    k        <= k_next;
    fill_q   <= fill_q_next;
    out_data <= out_data_next;
  end

endmodule

// ===== rtl/packet_parity_check_byte_generator_core.sv =====
// ----------------------------------------------------------------------------
// packet_parity_check_byte_generator_core
// Stamps the sequence number into byte 0, passes payload bytes and appends
// one check byte per group of three bytes at packet end.
// ----------------------------------------------------------------------------
// path: a payload or error result passes the command queue and then the result register
// throughput: one payload byte per cycle while the check engine is in its run state and
//   results are popped; at packet end the check engine completes the short group, then reads
//   out each check byte (one check store read each), while the 2-entry queue absorbs new bytes
// reset: synchronous; sequence number, counters and the queue clear, check store
//   contents are not cleared
module packet_parity_check_byte_generator_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ppcbg_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output ppcbg_pkg::out_item_t out_item
);
  import ppcbg_pkg::*;

  logic q_push, q_full, q_empty, q_pop;
  cmd_t q_wr_cmd, q_rd_cmd;

  ppcbg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .in_item(in_item),
    .q_push (q_push),
    .q_cmd  (q_wr_cmd),
    .q_full (q_full)
  );

  ppcbg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wr_cmd(q_wr_cmd),
    .full  (q_full),
    .empty (q_empty),
    .rd_cmd(q_rd_cmd),
    .rd    (q_pop)
  );

  ppcbg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_rd_cmd),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule

// ===== sim/packet_parity_check_byte_generator_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_parity_check_byte_generator_core_test
// Drives payload bytes of outgoing packets into the check byte generator and
// compares every framed byte, check byte and reject result against a local
// prediction of the framing. Covers short groups, oversize rejects, dropped
// bytes, length changes inside a packet and random stalls on both sides.
// ----------------------------------------------------------------------------
module packet_parity_check_byte_generator_core_test;
  import ppcbg_pkg::*;

  localparam int unsigned SIZE_LIMIT  = 128;
  localparam int unsigned STORE_DEPTH = 43;
  localparam int unsigned ITEM_TARGET = 330;

  localparam logic [7:0] GROUP_MASK [5][4] = '{
    '{8'hc0, 8'hc3, 8'hff, 8'h09},
    '{8'h38, 8'h3a, 8'h7e, 8'h13},
    '{8'h26, 8'hb5, 8'hb9, 8'h23},
    '{8'h95, 8'h6c, 8'hd5, 8'h43},
    '{8'h4b, 8'hdc, 8'he2, 8'h83}
  };

  typedef struct {
    in_item_t item;
    bit       drain;
  } feed_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  feed_t       feed_q[$];
  out_item_t   framed_q[$];

  // predicted framer state
  logic [1:0]  seq_num = 2'd0;
  int unsigned byte_cnt = 0;
  logic [4:0]  gpar = 5'd0;
  logic [7:0]  chk_store [STORE_DEPTH];
  bit          dropping = 1'b0;

  int unsigned total_items;
  int unsigned n_sent, n_seen, n_bad;
  int unsigned n_frames, n_reject, n_dropped, n_checks;
  int          src_gap, sink_gap;
  bit          src_jitter = 1'b1;
  bit          sink_jitter = 1'b1;
  bit          calm = 1'b0;

  packet_parity_check_byte_generator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  function automatic logic [4:0] fold_byte(input logic [4:0] gp, input logic [7:0] v,
                                           input int unsigned col);
    for (int b = 0; b < 5; b++) begin
      if (^(v & GROUP_MASK[b][col])) gp[b] = ~gp[b];
    end
    return gp;
  endfunction

  function automatic logic [7:0] seal_group(input logic [4:0] gp, input int unsigned g);
    logic [7:0] s;
    s = {5'd0, 3'(g)};
    for (int b = 0; b < 5; b++) begin
      if (gp[b] ^ (^(s & GROUP_MASK[b][3]))) s[b+3] = ~s[b+3];
    end
    return s;
  endfunction

  task automatic frame_in_byte(input in_item_t it);
    int unsigned nxt, pos, col, grp, nbytes, tgrp, idx;
    logic [7:0]  d, fill;
    out_item_t   r;
    d = it.data_byte;
    if (dropping) begin
      nxt = byte_cnt + 1;
      if (nxt >= it.packet_size || nxt >= 255) begin
        dropping = 1'b0;
        byte_cnt = 0;
      end else begin
        byte_cnt = nxt;
      end
      n_dropped++;
      return;
    end
    if (byte_cnt == 0 && (it.packet_size >= SIZE_LIMIT || it.packet_size == 0)) begin
      r = '{8'h00, 1'b0, 1'b0, 1'b1};
      framed_q.push_back(r);
      if (it.packet_size > 1) begin
        dropping = 1'b1;
        byte_cnt = 1;
      end
      n_reject++;
      return;
    end
    pos = byte_cnt;
    if (pos == 0) d = {1'b0, seq_num, d[4:0]};
    col = pos % 3;
    gpar = fold_byte(gpar, d, col);
    r = '{d, 1'b0, 1'b0, 1'b0};
    framed_q.push_back(r);
    nbytes = pos + 1;
    if (col == 2 && pos / 3 < STORE_DEPTH) begin
      chk_store[pos / 3] = seal_group(gpar, pos / 3);
      gpar = 5'd0;
    end
    if (!(nbytes >= it.packet_size || nbytes >= SIZE_LIMIT - 1)) begin
      byte_cnt = nbytes;
      return;
    end
    grp = (nbytes + 2) / 3;
    if (grp > STORE_DEPTH) grp = STORE_DEPTH;
    // short last group borrows earlier check bytes, or zero
    if (nbytes % 3 != 0) begin
      tgrp = nbytes / 3;
      for (int q = nbytes % 3; q < 3; q++) begin
        idx = 3 * tgrp + q - nbytes;
        fill = (idx < tgrp && idx < STORE_DEPTH) ? chk_store[idx] : 8'h00;
        gpar = fold_byte(gpar, fill, q);
      end
      if (tgrp < STORE_DEPTH) chk_store[tgrp] = seal_group(gpar, tgrp);
    end
    for (int k = 0; k < grp; k++) begin
      r = '{chk_store[k], 1'b1, (k + 1 == grp), 1'b0};
      framed_q.push_back(r);
    end
    gpar = 5'd0;
    byte_cnt = 0;
    seq_num = seq_num + 2'd1;
    n_frames++;
    n_checks += grp;
  endtask

  task automatic add_byte(input logic [7:0] d, input logic [7:0] sz, input bit drain);
    feed_t f;
    f.item.data_byte = d;
    f.item.packet_size = sz;
    f.drain = drain;
    feed_q.push_back(f);
  endtask

  task automatic add_packet(input int unsigned sz, input int unsigned nb, input bit drain);
    for (int i = 0; i < nb; i++) begin
      add_byte(8'($urandom), 8'(sz), drain && i == 0);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        frame_in_byte(in_item);
        n_sent++;
      end
      calm = (n_sent + 40 >= total_items);
      if ($urandom_range(0, 47) == 0) src_jitter = ~src_jitter;
      if (!push || !full) begin
        if (src_gap > 0) begin
          src_gap--;
          push <= 1'b0;
        end else if (feed_q.size() == 0 || (feed_q[0].drain && framed_q.size() != 0)) begin
          push <= 1'b0;
        end else if (!calm && src_jitter && $urandom_range(0, 3) == 0) begin
          src_gap = $urandom_range(0, 2);
          push <= 1'b0;
        end else begin
          push <= 1'b1;
          in_item <= feed_q[0].item;
          feed_q.pop_front();
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin : sink
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_seen++;
        if (framed_q.size() == 0) begin
          if (n_bad < 10)
            $display("unexpected transfer: byte %02h check %0b end %0b rej %0b",
                     out_item.out_byte, out_item.is_check, out_item.frame_end,
                     out_item.rejected);
          n_bad++;
        end else begin
          want = framed_q.pop_front();
          if (want.out_byte !== out_item.out_byte || want.is_check !== out_item.is_check ||
              want.frame_end !== out_item.frame_end || want.rejected !== out_item.rejected)
          begin
            if (n_bad < 10)
              $display("mismatch at result %0d: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                       n_seen, want.out_byte, want.is_check, want.frame_end, want.rejected,
                       out_item.out_byte, out_item.is_check, out_item.frame_end,
                       out_item.rejected);
            n_bad++;
          end
        end
      end
      if ($urandom_range(0, 47) == 0) sink_jitter = ~sink_jitter;
      if (sink_gap > 0) begin
        sink_gap--;
        pop <= 1'b0;
      end else if (!calm && sink_jitter && $urandom_range(0, 3) == 0) begin
        sink_gap = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned n_gen, sel, sz, k, j;
    bit          drain;
    for (int i = 0; i < STORE_DEPTH; i++) chk_store[i] = 8'h00;

    // directed: short groups, byte extremes, rejects, length changes
    add_byte(8'hff, 8'd1, 1'b0);
    add_byte(8'h00, 8'd2, 1'b0);
    add_byte(8'hff, 8'd2, 1'b0);
    add_byte(8'ha5, 8'd4, 1'b0);
    add_byte(8'h5a, 8'd4, 1'b0);
    add_byte(8'hff, 8'd4, 1'b0);
    add_byte(8'h00, 8'd4, 1'b0);
    add_packet(3, 3, 1'b0);
    add_byte(8'h7f, 8'd0, 1'b0);
    add_byte(8'h80, 8'd255, 1'b0);
    add_byte(8'hff, 8'd2, 1'b0);
    add_byte(8'h01, 8'd128, 1'b0);
    add_byte(8'hfe, 8'd1, 1'b0);
    add_byte(8'h3c, 8'd5, 1'b0);
    add_byte(8'hc3, 8'd2, 1'b0);
    add_byte(8'h00, 8'd127, 1'b0);
    add_byte(8'hff, 8'd1, 1'b0);

    // random: mostly well-formed packets, some rejects and noise
    add_packet(127, 127, 1'b1);
    n_gen = feed_q.size();
    while (n_gen < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      drain = ($urandom_range(0, 19) == 0);
      if (sel < 60) begin
        sz = $urandom_range(1, 12);
        add_packet(sz, sz, drain);
        n_gen += sz;
      end else if (sel < 74) begin
        sz = $urandom_range(13, 60);
        add_packet(sz, sz, drain);
        n_gen += sz;
      end else if (sel < 76) begin
        sz = $urandom_range(100, 127);
        add_packet(sz, sz, drain);
        n_gen += sz;
      end else if (sel < 86) begin
        case ($urandom_range(0, 7))
          0: sz = 0;
          1: sz = 128;
          2: sz = 255;
          default: sz = $urandom_range(128, 255);
        endcase
        add_byte(8'($urandom), 8'(sz), drain);
        n_gen++;
        if (sz != 0) begin
          if (sz <= 140) begin
            add_packet(sz, sz - 1, 1'b0);
            n_gen += sz - 1;
          end else begin
            k = $urandom_range(0, 3);
            add_packet(sz, k, 1'b0);
            add_byte(8'($urandom), 8'(k + 2), 1'b0);
            n_gen += k + 1;
          end
        end
      end else if (sel < 94) begin
        sz = $urandom_range(4, 20);
        j = $urandom_range(1, sz - 2);
        add_packet(sz, j, drain);
        add_byte(8'($urandom), 8'($urandom_range(1, j + 1)), 1'b0);
        n_gen += j + 1;
      end else begin
        add_byte(8'($urandom), 8'($urandom), drain);
        n_gen++;
      end
    end
    total_items = feed_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (feed_q.size() != 0 || push || framed_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d bytes in: %0d framed packets, %0d rejects, %0d bytes dropped",
             n_sent, n_frames, n_reject, n_dropped);
    $display("%0d transfers out checked, %0d of them check bytes, %0d mismatches",
             n_seen, n_checks, n_bad);
    if (n_bad == 0 && framed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
